@@ hw/rtl/jtl_pkg.sv @@
// jtl_pkg: shared types and constants for the JSON token lexer.
// No dependencies; every other file of the lexer but jtl_queue refers to it by scoped names.
package jtl_pkg;

  localparam int CHAR_BITS_DEF = 16;
  localparam int LINE_BITS_DEF = 32;
  localparam int MAX_RESULTS   = 3;
  localparam int QUEUE_DEPTH   = 4;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_STRING = 2'd1,
    MODE_BARE   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_TOKEN = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    TOK_COMMA  = 4'd0,
    TOK_COLON  = 4'd1,
    TOK_LBRACE = 4'd2,
    TOK_RBRACE = 4'd3,
    TOK_LBRACK = 4'd4,
    TOK_RBRACK = 4'd5,
    TOK_STRING = 4'd6,
    TOK_NUMBER = 4'd7,
    TOK_TRUE   = 4'd8,
    TOK_FALSE  = 4'd9,
    TOK_NULL   = 4'd10
  } tok_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_ESCAPE    = 3'd1,
    ERR_HEX_DIGIT = 3'd2,
    ERR_HEX_VALUE = 3'd3,
    ERR_UNKNOWN   = 3'd4,
    ERR_EOF       = 3'd5
  } err_t;

  // One result, minus its character and line.
  typedef struct packed {
    kind_t kind;
    tok_t  tok;
    err_t  err;
  } slot_t;

  // All results of one input character; count is 0..MAX_RESULTS.
  typedef struct packed {
    logic [1:0]              count;
    slot_t [MAX_RESULTS-1:0] slot;
  } meta_t;

endpackage

@@ hw/rtl/jtl_in_if.sv @@
// jtl_in_if: valid/ready channel carrying one input character.
// Depends on jtl_pkg for the default width.
interface jtl_in_if #(
  parameter int CHAR_BITS = jtl_pkg::CHAR_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] char_code;
  logic                 end_of_text;

  modport source (output valid, char_code, end_of_text, input ready);
  modport sink   (input valid, char_code, end_of_text, output ready);
endinterface

@@ hw/rtl/jtl_out_if.sv @@
// jtl_out_if: valid/ready channel carrying one lexer result.
// Depends on jtl_pkg for the default widths.
interface jtl_out_if #(
  parameter int CHAR_BITS = jtl_pkg::CHAR_BITS_DEF,
  parameter int LINE_BITS = jtl_pkg::LINE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           result_kind;
  logic [3:0]           token_type;
  logic [CHAR_BITS-1:0] char_value;
  logic [2:0]           error_code;
  logic [LINE_BITS-1:0] line_number;
  logic                 last_of_step;

  modport source (output valid, result_kind, token_type, char_value, error_code,
                  line_number, last_of_step, input ready);
  modport sink   (input valid, result_kind, token_type, char_value, error_code,
                  line_number, last_of_step, output ready);
endinterface

@@ hw/rtl/jtl_front.sv @@
// jtl_front: lexer state and per-character classification; emits a bundle
// of up to three results per accepted character. Depends on jtl_pkg, jtl_in_if.
module jtl_front #(
  parameter int CHAR_BITS = jtl_pkg::CHAR_BITS_DEF,
  parameter int LINE_BITS = jtl_pkg::LINE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  jtl_in_if.sink                   char_in,
  input  logic                     q_full,
  output logic                     push,
  output jtl_pkg::meta_t           meta,
  output logic [3*CHAR_BITS-1:0]   chars,
  output logic [LINE_BITS-1:0]     line
);

  typedef struct packed {
    logic          ok;
    jtl_pkg::tok_t tok;
  } cls_t;

  function automatic logic is_ch(input logic [CHAR_BITS-1:0] x, input logic [7:0] a);
    return x == CHAR_BITS'(a);
  endfunction

  function automatic logic in_rng(input logic [CHAR_BITS-1:0] x,
                                  input logic [7:0] lo, input logic [7:0] hi);
    return (x >= CHAR_BITS'(lo)) && (x <= CHAR_BITS'(hi));
  endfunction

  function automatic logic [7:0] kw_true_char(input logic [1:0] p);
    case (p)
      2'd0:    return "t";
      2'd1:    return "r";
      2'd2:    return "u";
      default: return "e";
    endcase
  endfunction

  function automatic logic [7:0] kw_null_char(input logic [1:0] p);
    case (p)
      2'd0:    return "n";
      2'd1:    return "u";
      default: return "l";
    endcase
  endfunction

  function automatic logic [7:0] kw_false_char(input logic [2:0] p);
    case (p)
      3'd0:    return "f";
      3'd1:    return "a";
      3'd2:    return "l";
      3'd3:    return "s";
      3'd4:    return "e";
      default: return 8'h00;
    endcase
  endfunction

  function automatic cls_t classify(input logic [2:0] cd, input logic [2:0] len,
                                    input logic fn);
    cls_t r;
    r.ok = 1'b1;
    if (cd[0] && len == 3'd4)      r.tok = jtl_pkg::TOK_TRUE;
    else if (cd[1] && len == 3'd5) r.tok = jtl_pkg::TOK_FALSE;
    else if (cd[2] && len == 3'd4) r.tok = jtl_pkg::TOK_NULL;
    else if (fn)                   r.tok = jtl_pkg::TOK_NUMBER;
    else begin
      r.ok  = 1'b0;
      r.tok = jtl_pkg::TOK_COMMA;
    end
    return r;
  endfunction

  jtl_pkg::mode_t       mode, mode_next;
  logic                 esc, esc_next;
  logic                 hex, hex_next;
  logic [2:0]           hcnt, hcnt_next;
  logic [15:0]          hacc, hacc_next;
  logic                 hinv, hinv_next;
  logic [2:0]           blen, blen_next;
  logic [2:0]           cand, cand_next;
  logic                 fnum, fnum_next;
  logic                 err, err_next;
  logic [LINE_BITS-1:0] line_count, line_next;
  logic [CHAR_BITS-1:0] chr [jtl_pkg::MAX_RESULTS];
  logic [1:0]           n;
  logic                 accept;

  assign char_in.ready = !q_full;
  assign accept        = char_in.valid && !q_full;
  assign push          = accept && (n != 2'd0);
  assign chars         = {chr[2], chr[1], chr[0]};
  assign line          = line_next;

  always_comb begin
    logic [CHAR_BITS-1:0] c;
    logic                 is_ws, is_dig, is_alpha, term, do_idle, do_add;
    logic [3:0]           hv;
    logic [15:0]          acc_t;
    logic [2:0]           cnt_t, p;
    cls_t                 cls;
    c        = char_in.char_code;
    is_ws    = in_rng(c, 8'h09, 8'h0D) || is_ch(c, 8'h20);
    is_dig   = in_rng(c, "0", "9");
    is_alpha = in_rng(c, "a", "z") || in_rng(c, "A", "Z");
    term     = is_ws || is_ch(c, ",") || is_ch(c, "]") || is_ch(c, "}");
    do_idle  = 1'b0;
    do_add   = 1'b0;
    hv       = 4'd0;
    acc_t    = 16'd0;
    cnt_t    = 3'd0;
    p        = 3'd0;
    cls      = '0;
    mode_next = mode;
    esc_next  = esc;
    hex_next  = hex;
    hcnt_next = hcnt;
    hacc_next = hacc;
    hinv_next = hinv;
    blen_next = blen;
    cand_next = cand;
    fnum_next = fnum;
    err_next  = err;
    line_next = line_count;
    n         = 2'd0;
    meta.slot = '0;
    for (int i = 0; i < jtl_pkg::MAX_RESULTS; i++) chr[i] = '0;

    if (!err) begin
      if (is_ch(c, 8'h0A) && line_count != {LINE_BITS{1'b1}}) line_next = line_count + 1'b1;

      case (mode)
        jtl_pkg::MODE_STRING: begin
          if (esc) begin
            esc_next = 1'b0;
            if (is_ch(c, "\"") || is_ch(c, "\\") || is_ch(c, "/")) begin
              meta.slot[n] = '{jtl_pkg::KIND_CHAR, jtl_pkg::TOK_STRING, jtl_pkg::ERR_NONE};
              chr[n] = c; n = n + 2'd1;
            end else if (is_ch(c, "b") || is_ch(c, "f") || is_ch(c, "n") ||
                         is_ch(c, "r") || is_ch(c, "t")) begin
              meta.slot[n] = '{jtl_pkg::KIND_CHAR, jtl_pkg::TOK_STRING, jtl_pkg::ERR_NONE};
              if (is_ch(c, "b"))      chr[n] = CHAR_BITS'(8'h08);
              else if (is_ch(c, "f")) chr[n] = CHAR_BITS'(8'h0C);
              else if (is_ch(c, "n")) chr[n] = CHAR_BITS'(8'h0A);
              else if (is_ch(c, "r")) chr[n] = CHAR_BITS'(8'h0D);
              else                    chr[n] = CHAR_BITS'(8'h09);
              n = n + 2'd1;
            end else if (is_ch(c, "u")) begin
              hex_next  = 1'b1;
              hcnt_next = 3'd0;
              hacc_next = 16'd0;
              hinv_next = 1'b0;
            end else begin
              err_next = 1'b1;
              meta.slot[n] = '{jtl_pkg::KIND_ERROR, jtl_pkg::TOK_COMMA, jtl_pkg::ERR_ESCAPE};
              n = n + 2'd1;
            end
          end else if (hex) begin
            if (!is_dig && !is_alpha) begin
              err_next = 1'b1;
              meta.slot[n] = '{jtl_pkg::KIND_ERROR, jtl_pkg::TOK_COMMA,
                               jtl_pkg::ERR_HEX_DIGIT};
              n = n + 2'd1;
            end else begin
              if (is_dig) hv = c[3:0];
              else if (in_rng(c, "a", "f") || in_rng(c, "A", "F")) hv = c[3:0] + 4'd9;
              else hinv_next = 1'b1;
              acc_t     = {hacc[11:0], hv};
              cnt_t     = hcnt + 3'd1;
              hacc_next = acc_t;
              hcnt_next = cnt_t;
              if (cnt_t >= 3'd4) begin
                if (hinv_next) begin
                  err_next = 1'b1;
                  meta.slot[n] = '{jtl_pkg::KIND_ERROR, jtl_pkg::TOK_COMMA,
                                   jtl_pkg::ERR_HEX_VALUE};
                  n = n + 2'd1;
                end else begin
                  meta.slot[n] = '{jtl_pkg::KIND_CHAR, jtl_pkg::TOK_STRING,
                                   jtl_pkg::ERR_NONE};
                  chr[n] = CHAR_BITS'(acc_t); n = n + 2'd1;
                  hex_next  = 1'b0;
                  hcnt_next = 3'd0;
                  hacc_next = 16'd0;
                end
              end
            end
          end else if (is_ch(c, "\\")) begin
            esc_next = 1'b1;
          end else if (is_ch(c, "\"")) begin
            mode_next = jtl_pkg::MODE_IDLE;
            meta.slot[n] = '{jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_STRING, jtl_pkg::ERR_NONE};
            n = n + 2'd1;
          end else begin
            meta.slot[n] = '{jtl_pkg::KIND_CHAR, jtl_pkg::TOK_STRING, jtl_pkg::ERR_NONE};
            chr[n] = c; n = n + 2'd1;
          end
        end
        jtl_pkg::MODE_BARE: begin
          if (term) begin
            cls       = classify(cand, blen, fnum);
            mode_next = jtl_pkg::MODE_IDLE;
            if (cls.ok) begin
              meta.slot[n] = '{jtl_pkg::KIND_TOKEN, cls.tok, jtl_pkg::ERR_NONE};
              n = n + 2'd1;
              do_idle = 1'b1;
            end else begin
              err_next = 1'b1;
              meta.slot[n] = '{jtl_pkg::KIND_ERROR, jtl_pkg::TOK_COMMA, jtl_pkg::ERR_UNKNOWN};
              n = n + 2'd1;
            end
          end else begin
            do_add = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      // between tokens (also the terminator of a bare token)
      if (do_idle && !is_ws) begin
        if (is_ch(c, ",") || is_ch(c, ":") || is_ch(c, "{") || is_ch(c, "}") ||
            is_ch(c, "[") || is_ch(c, "]")) begin
          meta.slot[n].kind = jtl_pkg::KIND_TOKEN;
          meta.slot[n].err  = jtl_pkg::ERR_NONE;
          if (is_ch(c, ","))      meta.slot[n].tok = jtl_pkg::TOK_COMMA;
          else if (is_ch(c, ":")) meta.slot[n].tok = jtl_pkg::TOK_COLON;
          else if (is_ch(c, "{")) meta.slot[n].tok = jtl_pkg::TOK_LBRACE;
          else if (is_ch(c, "}")) meta.slot[n].tok = jtl_pkg::TOK_RBRACE;
          else if (is_ch(c, "[")) meta.slot[n].tok = jtl_pkg::TOK_LBRACK;
          else                    meta.slot[n].tok = jtl_pkg::TOK_RBRACK;
          n = n + 2'd1;
        end else if (is_ch(c, "\"")) begin
          mode_next = jtl_pkg::MODE_STRING;
          esc_next  = 1'b0;
          hex_next  = 1'b0;
          hcnt_next = 3'd0;
          hacc_next = 16'd0;
          hinv_next = 1'b0;
        end else begin
          mode_next = jtl_pkg::MODE_BARE;
          blen_next = 3'd0;
          cand_next = 3'b111;
          fnum_next = 1'b0;
          do_add    = 1'b1;
        end
      end

      if (do_add) begin
        p = blen_next;
        if (p >= 3'd4 || !is_ch(c, kw_true_char(p[1:0]))) cand_next[0] = 1'b0;
        if (p >= 3'd5 || !is_ch(c, kw_false_char(p)))     cand_next[1] = 1'b0;
        if (p >= 3'd4 || !is_ch(c, kw_null_char(p[1:0]))) cand_next[2] = 1'b0;
        if (p == 3'd0) fnum_next = is_dig || is_ch(c, "-");
        if (p != 3'd7) blen_next = p + 3'd1;
        meta.slot[n] = '{jtl_pkg::KIND_CHAR, jtl_pkg::TOK_COMMA, jtl_pkg::ERR_NONE};
        chr[n] = c; n = n + 2'd1;
      end

      // end of text: close what is open, then report a clean end
      if (char_in.end_of_text && !err_next) begin
        if (mode_next == jtl_pkg::MODE_STRING) begin
          err_next = 1'b1;
          meta.slot[n] = '{jtl_pkg::KIND_ERROR, jtl_pkg::TOK_COMMA, jtl_pkg::ERR_EOF};
          n = n + 2'd1;
        end else if (mode_next == jtl_pkg::MODE_BARE) begin
          cls = classify(cand_next, blen_next, fnum_next);
          if (cls.ok) begin
            meta.slot[n] = '{jtl_pkg::KIND_TOKEN, cls.tok, jtl_pkg::ERR_NONE};
          end else begin
            err_next = 1'b1;
            meta.slot[n] = '{jtl_pkg::KIND_ERROR, jtl_pkg::TOK_COMMA, jtl_pkg::ERR_UNKNOWN};
          end
          n = n + 2'd1;
        end
        if (!err_next) begin
          meta.slot[n] = '{jtl_pkg::KIND_END, jtl_pkg::TOK_COMMA, jtl_pkg::ERR_NONE};
          n = n + 2'd1;
        end
        mode_next = jtl_pkg::MODE_IDLE;
        esc_next  = 1'b0;
        hex_next  = 1'b0;
        hcnt_next = 3'd0;
        hacc_next = 16'd0;
        hinv_next = 1'b0;
      end
    end

    meta.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= jtl_pkg::MODE_IDLE;
      esc        <= 1'b0;
      hex        <= 1'b0;
      hcnt       <= 3'd0;
      hacc       <= 16'd0;
      hinv       <= 1'b0;
      blen       <= 3'd0;
      cand       <= 3'b111;
      fnum       <= 1'b0;
      err        <= 1'b0;
      line_count <= LINE_BITS'(1);
    end else if (accept) begin
      mode       <= mode_next;
      esc        <= esc_next;
      hex        <= hex_next;
      hcnt       <= hcnt_next;
      hacc       <= hacc_next;
      hinv       <= hinv_next;
      blen       <= blen_next;
      cand       <= cand_next;
      fnum       <= fnum_next;
      err        <= err_next;
      line_count <= line_next;
    end
  end

endmodule

@@ hw/rtl/jtl_queue.sv @@
// jtl_queue: small register FIFO of result bundles between front and back.
// Depends on nothing but its parameters.
module jtl_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  output logic             valid,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    store [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] level;

  function automatic logic [PTR_BITS-1:0] bump(input logic [PTR_BITS-1:0] q);
    return (q == PTR_BITS'(DEPTH - 1)) ? '0 : q + 1'b1;
  endfunction

  assign full  = (level == CNT_BITS'(DEPTH));
  assign valid = (level != '0);
  assign rdata = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      level <= level + 1'b1;
      else if (pop && !push) level <= level - 1'b1;
    end
  end

endmodule

@@ hw/rtl/jtl_back.sv @@
// jtl_back: walks the head bundle one result at a time into the output register.
// Depends on jtl_pkg and jtl_out_if.
module jtl_back #(
  parameter int CHAR_BITS = jtl_pkg::CHAR_BITS_DEF,
  parameter int LINE_BITS = jtl_pkg::LINE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  jtl_pkg::meta_t         meta,
  input  logic [3*CHAR_BITS-1:0] chars,
  input  logic [LINE_BITS-1:0]   line,
  output logic                   q_pop,
  jtl_out_if.source              token_out
);

  logic                 valid;
  logic [1:0]           idx;
  logic                 last;
  logic                 load;
  jtl_pkg::slot_t       slot;
  logic [CHAR_BITS-1:0] chr;
  jtl_pkg::slot_t       o_slot;
  logic [CHAR_BITS-1:0] o_chr;
  logic [LINE_BITS-1:0] o_line;
  logic                 o_last;

  assign last  = (idx == meta.count - 2'd1);
  assign load  = q_valid && (!valid || token_out.ready);
  assign q_pop = load && last;

  always_comb begin
    case (idx)
      2'd1:    begin slot = meta.slot[1]; chr = chars[2*CHAR_BITS-1:CHAR_BITS]; end
      2'd2:    begin slot = meta.slot[2]; chr = chars[3*CHAR_BITS-1:2*CHAR_BITS]; end
      default: begin slot = meta.slot[0]; chr = chars[CHAR_BITS-1:0]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= last ? 2'd0 : idx + 2'd1;
    end else if (token_out.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_slot <= slot;
      o_chr  <= chr;
      o_line <= line;
      o_last <= last;
    end
  end

  assign token_out.valid        = valid;
  assign token_out.result_kind  = o_slot.kind;
  assign token_out.token_type   = o_slot.tok;
  assign token_out.char_value   = o_chr;
  assign token_out.error_code   = o_slot.err;
  assign token_out.line_number  = o_line;
  assign token_out.last_of_step = o_last;

endmodule

@@ hw/rtl/json_token_lexer.sv @@
// json_token_lexer: streaming JSON tokenizer, one character per input request.
// An accepted character's bundle is pushed into the queue, and its results then
// load one at a time into the output register (queue push, then output register).
// One character per cycle while each makes at most one result and token_out is
// ready; a character with several results holds the output register for each, and the
// four-bundle queue between front and back absorbs the bursts.
// Reset (rst, synchronous): idle between tokens, line count 1, queue empty.
module json_token_lexer #(
  parameter int CHAR_BITS = jtl_pkg::CHAR_BITS_DEF,
  parameter int LINE_BITS = jtl_pkg::LINE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  jtl_in_if.sink    char_in,
  jtl_out_if.source token_out
);

  // Bundle layout in the queue: meta | three characters | line number.
  localparam int META_BITS = $bits(jtl_pkg::meta_t);
  localparam int CHRS_BITS = jtl_pkg::MAX_RESULTS * CHAR_BITS;
  localparam int Q_WIDTH   = META_BITS + CHRS_BITS + LINE_BITS;

  // Front side: lexer state, classification of each character.
  logic                 f_push;
  jtl_pkg::meta_t       f_meta;
  logic [CHRS_BITS-1:0] f_chars;
  logic [LINE_BITS-1:0] f_line;

  // Queue side.
  logic                 q_full;
  logic                 q_valid;
  logic                 q_pop;
  logic [Q_WIDTH-1:0]   q_rdata;

  // Back side view of the head bundle.
  jtl_pkg::meta_t       b_meta;
  logic [CHRS_BITS-1:0] b_chars;
  logic [LINE_BITS-1:0] b_line;

  // The front takes a character whenever the queue has room, regardless of
  // whether the output is stalled; an error stops all further results but
  // characters are still taken and dropped.
  jtl_front #(
    .CHAR_BITS (CHAR_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_in),
    .q_full  (q_full),
    .push    (f_push),
    .meta    (f_meta),
    .chars   (f_chars),
    .line    (f_line)
  );

  jtl_queue #(
    .WIDTH (Q_WIDTH),
    .DEPTH (jtl_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata ({f_meta, f_chars, f_line}),
    .full  (q_full),
    .valid (q_valid),
    .pop   (q_pop),
    .rdata (q_rdata)
  );

  assign b_meta  = jtl_pkg::meta_t'(q_rdata[Q_WIDTH-1 -: META_BITS]);
  assign b_chars = q_rdata[LINE_BITS +: CHRS_BITS];
  assign b_line  = q_rdata[LINE_BITS-1:0];

  // Back side: one result per cycle into the output register while token_out is ready;
  // the bundle is popped when its last result loads.
  jtl_back #(
    .CHAR_BITS (CHAR_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .meta      (b_meta),
    .chars     (b_chars),
    .line      (b_line),
    .q_pop     (q_pop),
    .token_out (token_out)
  );

`ifndef NO_ASSERTIONS
  // Never write a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) f_push |-> !q_full)
    else $error("bundle pushed into full queue");

  // Never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");

  // Errors and clean ends always close the results of their character.
  a_final_last: assert property (@(posedge clk) disable iff (rst)
      token_out.valid && (token_out.result_kind == jtl_pkg::KIND_ERROR ||
                          token_out.result_kind == jtl_pkg::KIND_END)
      |-> token_out.last_of_step)
    else $error("error or end result not last of its step");

  // Every stored bundle holds at least one result.
  a_bundle_nonempty: assert property (@(posedge clk) disable iff (rst)
      q_valid |-> (b_meta.count != 2'd0))
    else $error("empty bundle in queue");
`endif

endmodule

@@ bench/json_token_lexer_tb.sv @@
// json_token_lexer_tb: self-checking bench for the streaming JSON token lexer.
// Needs jtl_pkg, jtl_in_if, jtl_out_if and json_token_lexer; drives characters,
// predicts every result in-bench and checks them in order on token_out.
module json_token_lexer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 10;

  // ASCII codes the lexer reacts to
  localparam logic [15:0] CH_LF     = 16'h000A;
  localparam logic [15:0] CH_SPACE  = 16'h0020;
  localparam logic [15:0] CH_QUOTE  = 16'h0022;
  localparam logic [15:0] CH_COMMA  = 16'h002C;
  localparam logic [15:0] CH_MINUS  = 16'h002D;
  localparam logic [15:0] CH_SLASH  = 16'h002F;
  localparam logic [15:0] CH_COLON  = 16'h003A;
  localparam logic [15:0] CH_LBRACK = 16'h005B;
  localparam logic [15:0] CH_BSLASH = 16'h005C;
  localparam logic [15:0] CH_RBRACK = 16'h005D;
  localparam logic [15:0] CH_LBRACE = 16'h007B;
  localparam logic [15:0] CH_RBRACE = 16'h007D;

  // token_type is 0 on error/end results and on bare-token characters
  localparam jtl_pkg::tok_t TOK_NONE = jtl_pkg::TOK_COMMA;

  // One result as seen on token_out
  typedef struct packed {
    jtl_pkg::kind_t kind;
    jtl_pkg::tok_t  tok;
    logic [15:0]    chr;
    jtl_pkg::err_t  err;
    logic [31:0]    line;
    logic           last;
  } lexeme_t;

  // Directed row: a character, its end flag, and optionally the one result
  // it must give, typed in by hand
  typedef struct packed {
    logic [15:0] code;
    logic        eot;
    logic        typed;
    lexeme_t     want;
  } stim_row_t;

  localparam int NUM_DIRECTED = 25;

  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // first request after reset: comma on line 1
    '{CH_COMMA,  1'b0, 1'b1, '{jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_COMMA, 16'h0000,
                               jtl_pkg::ERR_NONE, 32'd1, 1'b1}},
    '{CH_COLON,  1'b0, 1'b0, '0},
    '{CH_LBRACE, 1'b0, 1'b0, '0},
    '{CH_RBRACE, 1'b0, 1'b0, '0},
    '{CH_LBRACK, 1'b0, 1'b0, '0},
    '{CH_RBRACK, 1'b0, 1'b0, '0},
    '{CH_SPACE,  1'b0, 1'b0, '0},
    '{CH_LF,     1'b0, 1'b0, '0},          // line 2 from here
    '{CH_QUOTE,  1'b0, 1'b0, '0},
    // extreme code units pass through a string unchanged
    '{16'hFFFF,  1'b0, 1'b1, '{jtl_pkg::KIND_CHAR, jtl_pkg::TOK_STRING, 16'hFFFF,
                               jtl_pkg::ERR_NONE, 32'd2, 1'b1}},
    '{16'h0000,  1'b0, 1'b1, '{jtl_pkg::KIND_CHAR, jtl_pkg::TOK_STRING, 16'h0000,
                               jtl_pkg::ERR_NONE, 32'd2, 1'b1}},
    '{CH_BSLASH, 1'b0, 1'b0, '0},          // \uFf09, mixed-case hex
    '{16'h0075,  1'b0, 1'b0, '0},
    '{16'h0046,  1'b0, 1'b0, '0},
    '{16'h0066,  1'b0, 1'b0, '0},
    '{16'h0030,  1'b0, 1'b0, '0},
    '{16'h0039,  1'b0, 1'b0, '0},
    '{CH_QUOTE,  1'b0, 1'b0, '0},
    '{CH_MINUS,  1'b0, 1'b0, '0},          // number with a fullwidth comma inside:
    '{16'hFF0C,  1'b0, 1'b0, '0},          // wide codes never terminate a token
    '{CH_RBRACK, 1'b0, 1'b0, '0},          // closes number, then gives ]
    '{16'h006E,  1'b0, 1'b0, '0},          // n u l l + end of text: three results
    '{16'h0075,  1'b0, 1'b0, '0},
    '{16'h006C,  1'b0, 1'b0, '0},
    '{16'h006C,  1'b1, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  jtl_in_if  char_ch ();
  jtl_out_if tok_ch ();

  json_token_lexer uut (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_ch),
    .token_out (tok_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Lexer predictor state (mirrors the block after reset)
  // ---------------------------------------------------------------------------
  jtl_pkg::mode_t scan_mode = jtl_pkg::MODE_IDLE;
  bit          esc_wait     = 1'b0;   // backslash seen inside a string
  bit          in_uhex      = 1'b0;   // collecting \uXXXX digits
  int          uhex_count   = 0;
  logic [15:0] uhex_value   = '0;
  bit          uhex_bad     = 1'b0;   // a non-hex letter was taken as a digit
  int          word_len     = 0;      // bare token length, saturates at 7
  bit [2:0]    word_match   = 3'b111; // still could be true / false / null
  bit          word_numeric = 1'b0;
  bit          halted       = 1'b0;   // sticky error
  logic [31:0] cur_line     = 32'd1;
  logic [31:0] halt_line    = '0;

  string kw_word [3] = '{"true", "false", "null"};

  lexeme_t     step_q [$];            // results of the character just taken
  lexeme_t     lexeme_q [$];          // results still owed by the block
  logic [16:0] pending_chars [$];     // {end_of_text, char} waiting to be sent

  int fails   = 0;
  int sent    = 0;
  int tx_calm = 0;
  int rx_calm = 0;

  function automatic bit is_space(logic [15:0] c);
    return (c >= 16'h0009 && c <= 16'h000D) || c == CH_SPACE;
  endfunction

  function automatic bit is_digit(logic [15:0] c);
    return c >= 16'h0030 && c <= 16'h0039;
  endfunction

  function automatic bit is_alpha(logic [15:0] c);
    return (c >= 16'h0061 && c <= 16'h007A) || (c >= 16'h0041 && c <= 16'h005A);
  endfunction

  // Characters that close a bare token
  function automatic bit ends_word(logic [15:0] c);
    return is_space(c) || c == CH_COMMA || c == CH_RBRACK || c == CH_RBRACE;
  endfunction

  function automatic void emit(jtl_pkg::kind_t k, jtl_pkg::tok_t t, logic [15:0] v,
                               jtl_pkg::err_t e, logic [31:0] ln);
    if (step_q.size() < jtl_pkg::MAX_RESULTS)
      step_q.push_back('{k, t, v, e, ln, 1'b0});
  endfunction

  function automatic void halt(jtl_pkg::err_t e);
    halted    = 1'b1;
    halt_line = cur_line;
    emit(jtl_pkg::KIND_ERROR, TOK_NONE, '0, e, halt_line);
  endfunction

  function automatic void clear_escape();
    esc_wait   = 1'b0;
    in_uhex    = 1'b0;
    uhex_count = 0;
    uhex_value = '0;
    uhex_bad   = 1'b0;
  endfunction

  function automatic void word_add(logic [15:0] c);
    for (int k = 0; k < 3; k++) begin
      if (word_len >= kw_word[k].len() || c != 16'(kw_word[k][word_len]))
        word_match[k] = 1'b0;
    end
    if (word_len == 0)
      word_numeric = is_digit(c) || c == CH_MINUS;
    if (word_len < 7)
      word_len++;
    emit(jtl_pkg::KIND_CHAR, TOK_NONE, c, jtl_pkg::ERR_NONE, cur_line);
  endfunction

  // Classify the finished bare token; 0 means it was an unknown token
  function automatic bit word_close();
    jtl_pkg::tok_t t;
    scan_mode = jtl_pkg::MODE_IDLE;
    if (word_match[0] && word_len == 4)
      t = jtl_pkg::TOK_TRUE;
    else if (word_match[1] && word_len == 5)
      t = jtl_pkg::TOK_FALSE;
    else if (word_match[2] && word_len == 4)
      t = jtl_pkg::TOK_NULL;
    else if (word_numeric)
      t = jtl_pkg::TOK_NUMBER;
    else begin
      halt(jtl_pkg::ERR_UNKNOWN);
      return 1'b0;
    end
    emit(jtl_pkg::KIND_TOKEN, t, '0, jtl_pkg::ERR_NONE, cur_line);
    return 1'b1;
  endfunction

  function automatic void idle_char(logic [15:0] c);
    if (is_space(c))
      return;
    case (c)
      CH_COMMA:  emit(jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_COMMA, '0, jtl_pkg::ERR_NONE,
                      cur_line);
      CH_COLON:  emit(jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_COLON, '0, jtl_pkg::ERR_NONE,
                      cur_line);
      CH_LBRACE: emit(jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_LBRACE, '0, jtl_pkg::ERR_NONE,
                      cur_line);
      CH_RBRACE: emit(jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_RBRACE, '0, jtl_pkg::ERR_NONE,
                      cur_line);
      CH_LBRACK: emit(jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_LBRACK, '0, jtl_pkg::ERR_NONE,
                      cur_line);
      CH_RBRACK: emit(jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_RBRACK, '0, jtl_pkg::ERR_NONE,
                      cur_line);
      CH_QUOTE: begin
        scan_mode = jtl_pkg::MODE_STRING;
        clear_escape();
      end
      default: begin
        scan_mode    = jtl_pkg::MODE_BARE;
        word_len     = 0;
        word_match   = 3'b111;
        word_numeric = 1'b0;
        word_add(c);
      end
    endcase
  endfunction

  // Advance the predictor by one accepted character; results land in step_q
  function automatic void tokenize_char(logic [15:0] c, bit eot);
    logic [3:0] nib;
    step_q.delete();
    if (halted)
      return;
    // newline bumps the line before the character itself is looked at
    if (c == CH_LF && cur_line != '1)
      cur_line++;

    case (scan_mode)
      jtl_pkg::MODE_STRING: begin
        if (esc_wait) begin
          esc_wait = 1'b0;
          case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH:
                 emit(jtl_pkg::KIND_CHAR, jtl_pkg::TOK_STRING, c, jtl_pkg::ERR_NONE,
                      cur_line);
            "b": emit(jtl_pkg::KIND_CHAR, jtl_pkg::TOK_STRING, 16'h0008,
                      jtl_pkg::ERR_NONE, cur_line);
            "f": emit(jtl_pkg::KIND_CHAR, jtl_pkg::TOK_STRING, 16'h000C,
                      jtl_pkg::ERR_NONE, cur_line);
            "n": emit(jtl_pkg::KIND_CHAR, jtl_pkg::TOK_STRING, 16'h000A,
                      jtl_pkg::ERR_NONE, cur_line);
            "r": emit(jtl_pkg::KIND_CHAR, jtl_pkg::TOK_STRING, 16'h000D,
                      jtl_pkg::ERR_NONE, cur_line);
            "t": emit(jtl_pkg::KIND_CHAR, jtl_pkg::TOK_STRING, 16'h0009,
                      jtl_pkg::ERR_NONE, cur_line);
            "u": begin
              in_uhex    = 1'b1;
              uhex_count = 0;
              uhex_value = '0;
              uhex_bad   = 1'b0;
            end
            default: halt(jtl_pkg::ERR_ESCAPE);
          endcase
        end else if (in_uhex) begin
          // non-alphanumeric fails at once; a letter past F fails on digit four
          if (!is_digit(c) && !is_alpha(c))
            halt(jtl_pkg::ERR_HEX_DIGIT);
          else begin
            nib = '0;
            if (is_digit(c))
              nib = 4'(c - 16'h0030);
            else if (c >= 16'h0061 && c <= 16'h0066)
              nib = 4'(c - 16'h0061 + 16'd10);
            else if (c >= 16'h0041 && c <= 16'h0046)
              nib = 4'(c - 16'h0041 + 16'd10);
            else
              uhex_bad = 1'b1;
            uhex_value = {uhex_value[11:0], nib};
            uhex_count++;
            if (uhex_count >= 4) begin
              if (uhex_bad)
                halt(jtl_pkg::ERR_HEX_VALUE);
              else begin
                emit(jtl_pkg::KIND_CHAR, jtl_pkg::TOK_STRING, uhex_value,
                     jtl_pkg::ERR_NONE, cur_line);
                in_uhex    = 1'b0;
                uhex_count = 0;
                uhex_value = '0;
              end
            end
          end
        end else if (c == CH_BSLASH)
          esc_wait = 1'b1;
        else if (c == CH_QUOTE) begin
          scan_mode = jtl_pkg::MODE_IDLE;
          emit(jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_STRING, '0, jtl_pkg::ERR_NONE, cur_line);
        end else
          emit(jtl_pkg::KIND_CHAR, jtl_pkg::TOK_STRING, c, jtl_pkg::ERR_NONE, cur_line);
      end
      jtl_pkg::MODE_BARE: begin
        // the terminator is handled again as a fresh character
        if (ends_word(c)) begin
          if (word_close())
            idle_char(c);
        end else
          word_add(c);
      end
      default: idle_char(c);
    endcase

    if (eot && !halted) begin
      if (scan_mode == jtl_pkg::MODE_STRING)
        halt(jtl_pkg::ERR_EOF);
      else if (scan_mode == jtl_pkg::MODE_BARE)
        void'(word_close());
      if (!halted)
        emit(jtl_pkg::KIND_END, TOK_NONE, '0, jtl_pkg::ERR_NONE, cur_line);
      scan_mode = jtl_pkg::MODE_IDLE;
      clear_escape();
    end

    if (step_q.size() > 0)
      step_q[step_q.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Random text builders
  // ---------------------------------------------------------------------------
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    // now and then a burst with no idle cycles at all
    if ($urandom_range(0, 11) == 0) begin
      calm = $urandom_range(5, 25);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [15:0] pick(string s);
    return 16'(s[$urandom_range(0, s.len() - 1)]);
  endfunction

  function automatic logic [15:0] rand_space();
    logic [15:0] v;
    v = 16'h0009 + 16'($urandom_range(0, 5));
    return (v == 16'h000E) ? CH_SPACE : v;
  endfunction

  function automatic logic [15:0] rand_ending();
    return $urandom_range(0, 1) ? rand_space() : pick(",]}");
  endfunction

  // plain string content: anything but quote and backslash
  function automatic logic [15:0] text_char();
    logic [15:0] v;
    do begin
      if ($urandom_range(0, 2) == 0)
        v = 16'($urandom);
      else
        v = 16'($urandom_range(32, 126));
    end while (v == CH_QUOTE || v == CH_BSLASH);
    return v;
  endfunction

  function automatic void queue_char(logic [15:0] c);
    pending_chars.push_back({1'b0, c});
  endfunction

  function automatic void mark_end();
    pending_chars[pending_chars.size() - 1][16] = 1'b1;
  endfunction

  // n pieces of string body: plain characters, short escapes and \uXXXX
  function automatic void add_text(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 6)
        queue_char(text_char());
      else if (r < 8) begin
        queue_char(CH_BSLASH);
        queue_char(pick("\"\\/bfnrt"));
      end else begin
        queue_char(CH_BSLASH);
        queue_char("u");
        for (int d = 0; d < 4; d++)
          queue_char(pick("0123456789abcdefABCDEF"));
      end
    end
  endfunction

  // a keyword or a number, closed by a terminator or by end of text
  function automatic void add_word();
    logic [15:0] v;
    int n;
    if ($urandom_range(0, 2) == 0) begin
      n = $urandom_range(0, 2);
      for (int i = 0; i < kw_word[n].len(); i++)
        queue_char(16'(kw_word[n][i]));
    end else begin
      queue_char($urandom_range(0, 3) == 0 ? CH_MINUS : pick("0123456789"));
      n = $urandom_range(0, 9);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          do v = 16'($urandom); while (ends_word(v));
          queue_char(v);
        end else
          queue_char(pick("0123456789.eE+-"));
      end
    end
    if ($urandom_range(0, 5) == 0)
      mark_end();
    else
      queue_char(rand_ending());
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one request per character, random gap before each
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [15:0] c, input bit eot, input bit typed,
                           input lexeme_t want);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      char_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_ch.valid       <= 1'b1;
    char_ch.char_code   <= c;
    char_ch.end_of_text <= eot;
    do @(posedge clk); while (!char_ch.ready);
    // accepted at this edge: record what the block now owes
    tokenize_char(c, eot);
    if (typed)
      lexeme_q.push_back(want);
    else
      foreach (step_q[i])
        lexeme_q.push_back(step_q[i]);
  endtask

  task automatic send_pending();
    logic [16:0] x;
    while (pending_chars.size() > 0) begin
      x = pending_chars.pop_front();
      send_char(x[15:0], x[16], 1'b0, '0);
      sent++;
    end
  endtask

  // Sender holds off until the block has handed over everything owed
  task automatic drain_all();
    char_ch.valid <= 1'b0;
    while (lexeme_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall before each result, check against prediction
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [31:0] want,
                                        logic [31:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, want, got);
    end
  endfunction

  initial begin
    int stall;
    lexeme_t want;
    tok_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_gap(rx_calm);
      if (stall > 0) begin
        tok_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      tok_ch.ready <= 1'b1;
      do @(posedge clk); while (!tok_ch.valid);
      if (lexeme_q.size() == 0) begin
        fails++;
        $display("%0t: unexpected result, expected none, actual kind %0d type %0d char 0x%0h",
                 $time, tok_ch.result_kind, tok_ch.token_type, tok_ch.char_value);
      end else begin
        want = lexeme_q.pop_front();
        compare_field("result_kind",  want.kind, tok_ch.result_kind);
        compare_field("token_type",   want.tok,  tok_ch.token_type);
        compare_field("char_value",   want.chr,  tok_ch.char_value);
        compare_field("error_code",   want.err,  tok_ch.error_code);
        compare_field("line_number",  want.line, tok_ch.line_number);
        compare_field("last_of_step", want.last, tok_ch.last_of_step);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed table, random well-formed text, one breaking sequence
  // at the end (errors are sticky and reset is applied only once), then a few
  // characters that must be ignored.
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    int tries;
    bit pressured;
    logic [15:0] v;
    char_ch.valid       <= 1'b0;
    char_ch.char_code   <= '0;
    char_ch.end_of_text <= 1'b0;
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_char(DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].eot, DIRECTED_ROWS[i].typed,
                DIRECTED_ROWS[i].want);
      sent++;
    end
    drain_all();

    // Mostly valid JSON tokens with random content; an occasional end of
    // text between tokens restarts the stream without clearing the line.
    pressured = 1'b0;
    while (sent < 230) begin
      case ($urandom_range(0, 9))
        0, 1, 2: queue_char(pick(",:{}[]"));
        3, 4:    queue_char(rand_space());
        5, 6: begin
          queue_char(CH_QUOTE);
          add_text($urandom_range(0, 6));
          queue_char(CH_QUOTE);
        end
        default: add_word();
      endcase
      if (pending_chars[pending_chars.size() - 1][16] == 1'b0 && $urandom_range(0, 9) == 0)
        mark_end();
      send_pending();
      if (!pressured && sent >= 130) begin
        drain_all();
        pressured = 1'b1;
      end
    end

    // One broken sequence, chosen per run
    case ($urandom_range(0, 5))
      0: begin  // bad escape letter
        queue_char(CH_QUOTE);
        add_text($urandom_range(0, 3));
        queue_char(CH_BSLASH);
        do v = $urandom_range(0, 1) ? 16'($urandom_range(32, 126)) : 16'($urandom);
        while (v inside {CH_QUOTE, CH_BSLASH, CH_SLASH, "b", "f", "n", "r", "t", "u"});
        queue_char(v);
      end
      1: begin  // non-alphanumeric inside \u
        queue_char(CH_QUOTE);
        queue_char(CH_BSLASH);
        queue_char("u");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
          queue_char(pick("0123456789abcdefABCDEF"));
        do v = 16'($urandom); while (is_digit(v) || is_alpha(v));
        queue_char(v);
      end
      2: begin  // letter past F inside \u, caught on the fourth digit
        queue_char(CH_QUOTE);
        queue_char(CH_BSLASH);
        queue_char("u");
        n = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++)
          queue_char(i == n ? pick("ghijklmnopqrstuvwxyzGHIJKLMNOPQRSTUVWXYZ")
                            : pick("0123456789abcdefABCDEFxyzXYZ"));
      end
      3: begin  // unknown bare word
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          queue_char(pick("abcdefghijklmnopqrstuvwxyz"));
        queue_char(rand_ending());
      end
      4: begin  // end of text inside a string, maybe right after a backslash
        queue_char(CH_QUOTE);
        add_text($urandom_range(0, 3));
        if ($urandom_range(0, 1))
          queue_char(CH_BSLASH);
        mark_end();
      end
      default: ;  // noise alone
    endcase
    send_pending();

    // noise until the error latches (a keyword-shaped word may slip through)
    tries = 0;
    while (!halted && tries < 40) begin
      v = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(32, 126));
      send_char(v, $urandom_range(0, 19) == 0, 1'b0, '0);
      tries++;
    end

    // after the error nothing more may come out
    repeat (6)
      send_char(16'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);

    char_ch.valid <= 1'b0;
    while (lexeme_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #3ms;
    $display("%0t: timeout with %0d results outstanding", $time, lexeme_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
